// ===== sv/lbp_pkg.sv =====
// ============================================================================
// lbp_pkg: shared definitions for the buffer pool directory
// Operation codes, default sizes and the command that drives the slot table.
// ============================================================================
package lbp_pkg;

    localparam int DEF_SLOTS          = 16;
    localparam int DEF_FILE_ID_BITS   = 8;
    localparam int DEF_BLOCK_NUM_BITS = 24;

    // widest slot index over the supported range of slot counts
    localparam int MAX_SLOT_W = 6;

    localparam logic [1:0] OP_READ   = 2'd0;
    localparam logic [1:0] OP_WRITE  = 2'd1;
    localparam logic [1:0] OP_REMOVE = 2'd2;

    typedef enum logic [2:0] {
        CMD_NONE,
        CMD_REMOVE,
        CMD_TOUCH,
        CMD_MARK_DIRTY,
        CMD_FILL
    } slot_cmd_kind_t;

    typedef struct packed {
        slot_cmd_kind_t          kind;
        logic [MAX_SLOT_W-1:0]   slot;
        logic                    dirty_wr;
        logic                    dirty_val;
    } slot_cmd_t;

endpackage

// ===== sv/lbp_ram.sv =====
// ============================================================================
// lbp_ram: generic single-write, single-read RAM
// One write port and one read port; read data is registered.
// ============================================================================
module lbp_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== sv/lbp_rank_table.sv =====
// ============================================================================
// lbp_rank_table: per-slot valid, dirty and recency rank
// Applies one slot command a cycle and keeps the count of valid slots.
// ============================================================================
module lbp_rank_table
    import lbp_pkg::*;
#(
    parameter int SLOTS = DEF_SLOTS
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  slot_cmd_t                             cmd,
    output logic [SLOTS-1:0]                      valid_vec,
    output logic [SLOTS-1:0]                      dirty_vec,
    output logic [SLOTS-1:0][$clog2(SLOTS)-1:0]   rank_vec,
    output logic [$clog2(SLOTS+1)-1:0]            count
);

    localparam int SLOT_W  = $clog2(SLOTS);
    localparam int COUNT_W = $clog2(SLOTS+1);

    logic [SLOTS-1:0]             valid_reg, valid_next;
    logic [SLOTS-1:0]             dirty_reg, dirty_next;
    logic [SLOTS-1:0][SLOT_W-1:0] rank_reg,  rank_next;
    logic [COUNT_W-1:0]           count_reg, count_next;

    logic [SLOT_W-1:0] sel;
    logic [SLOT_W-1:0] sel_rank;
    logic [SLOTS-1:0]  dec_mask;

    assign sel      = cmd.slot[SLOT_W-1:0];
    assign sel_rank = rank_reg[sel];

    always_comb
    begin
        for (int i = 0; i < SLOTS; i++)
        begin
            dec_mask[i] = valid_reg[i] && (SLOT_W'(i) != sel) && (rank_reg[i] > sel_rank);
        end
    end

    always_comb
    begin
        valid_next = valid_reg;
        dirty_next = dirty_reg;
        rank_next  = rank_reg;
        count_next = count_reg;
        unique case (cmd.kind)
            CMD_NONE:
            begin
            end
            CMD_REMOVE:
            begin
                for (int i = 0; i < SLOTS; i++)
                begin
                    if (dec_mask[i])
                    begin
                        rank_next[i] = rank_reg[i] - SLOT_W'(1);
                    end
                end
                valid_next[sel] = 1'b0;
                dirty_next[sel] = 1'b0;
                rank_next[sel]  = '0;
                count_next      = count_reg - COUNT_W'(1);
            end
            CMD_TOUCH:
            begin
                for (int i = 0; i < SLOTS; i++)
                begin
                    if (dec_mask[i])
                    begin
                        rank_next[i] = rank_reg[i] - SLOT_W'(1);
                    end
                end
                rank_next[sel] = SLOT_W'(count_reg - COUNT_W'(1));
                if (cmd.dirty_wr)
                begin
                    dirty_next[sel] = cmd.dirty_val;
                end
            end
            CMD_MARK_DIRTY:
            begin
                dirty_next[sel] = 1'b1;
            end
            CMD_FILL:
            begin
                valid_next[sel] = 1'b1;
                dirty_next[sel] = cmd.dirty_val;
                rank_next[sel]  = SLOT_W'(count_reg);
                count_next      = count_reg + COUNT_W'(1);
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            dirty_reg <= '0;
            rank_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
            dirty_reg <= dirty_next;
            rank_reg  <= rank_next;
            count_reg <= count_next;
        end
    end

    assign valid_vec = valid_reg;
    assign dirty_vec = dirty_reg;
    assign rank_vec  = rank_reg;
    assign count     = count_reg;

    a_count_matches_valid: assert property (@(posedge clk) disable iff (!rst_n)
        $countones(valid_reg) == int'(count_reg))
        else $error("valid count out of step with valid bits");

    a_count_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= COUNT_W'(SLOTS))
        else $error("valid count exceeds slot count");

    a_fill_has_room: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.kind == CMD_FILL) |-> (count_reg < COUNT_W'(SLOTS)))
        else $error("fill with no free slot");

endmodule

// ===== sv/lru_buffer_pool_directory_core.sv =====
// ============================================================================
// lru_buffer_pool_directory_core: LRU directory of a block buffer pool
// Scans every slot's tag through one shared compare unit, then applies the
// hit, fill or eviction to the slot table; a file removal clears each matching slot as the scan finds it.
// A new transaction is accepted only in idle, once the previous result has been issued;
// the tag scan reads one slot a cycle through the single read port of the tag RAM.
// Reset: all slots invalid, clean, rank zero; tag RAM is not cleared.
// ============================================================================
module lru_buffer_pool_directory_core
    import lbp_pkg::*;
#(
    parameter int SLOTS          = DEF_SLOTS,
    parameter int FILE_ID_BITS   = DEF_FILE_ID_BITS,
    parameter int BLOCK_NUM_BITS = DEF_BLOCK_NUM_BITS
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic [1:0]                   opcode,
    input  logic [FILE_ID_BITS-1:0]      file_id,
    input  logic [BLOCK_NUM_BITS-1:0]    block_num,
    input  logic                         content_differs,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic                         hit,
    output logic [$clog2(SLOTS)-1:0]     slot,
    output logic                         victim_valid,
    output logic                         victim_dirty,
    output logic [FILE_ID_BITS-1:0]      victim_file,
    output logic [BLOCK_NUM_BITS-1:0]    victim_block,
    output logic [$clog2(SLOTS+1)-1:0]   removed_count
);

    localparam int SLOT_W  = $clog2(SLOTS);
    localparam int COUNT_W = $clog2(SLOTS+1);
    localparam int TAG_W   = FILE_ID_BITS + BLOCK_NUM_BITS;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_FINISH
    } state_t;

    state_t state_reg;

    logic [SLOT_W-1:0]         scan_idx_reg;
    logic                      cmp_en_reg;
    logic [SLOT_W-1:0]         cmp_idx_reg;

    logic [1:0]                op_reg;
    logic [FILE_ID_BITS-1:0]   key_file_reg;
    logic [BLOCK_NUM_BITS-1:0] key_block_reg;
    logic                      differs_reg;

    logic                      hit_found_reg;
    logic [SLOT_W-1:0]         hit_slot_reg;
    logic                      free_found_reg;
    logic [SLOT_W-1:0]         free_slot_reg;
    logic [SLOT_W-1:0]         lru_slot_reg;
    logic [FILE_ID_BITS-1:0]   vic_file_reg;
    logic [BLOCK_NUM_BITS-1:0] vic_block_reg;
    logic [COUNT_W-1:0]        removed_reg;

    logic                      out_valid_reg;
    logic                      hit_reg;
    logic [SLOT_W-1:0]         slot_reg;
    logic                      victim_valid_reg;
    logic                      victim_dirty_reg;
    logic [FILE_ID_BITS-1:0]   victim_file_reg;
    logic [BLOCK_NUM_BITS-1:0] victim_block_reg;
    logic [COUNT_W-1:0]        removed_count_reg;

    logic [TAG_W-1:0]          rd_tag;
    logic [FILE_ID_BITS-1:0]   rd_file;
    logic [BLOCK_NUM_BITS-1:0] rd_block;
    logic                      ram_we;
    logic [SLOT_W-1:0]         ram_waddr;

    logic [SLOTS-1:0]              valid_vec;
    logic [SLOTS-1:0]              dirty_vec;
    logic [SLOTS-1:0][SLOT_W-1:0]  rank_vec;
    logic [COUNT_W-1:0]            valid_count;
    slot_cmd_t                     cmd;

    logic in_fire;
    logic finish_go;
    logic is_access;
    logic is_remove;
    logic cur_valid;
    logic cur_rank_zero;
    logic file_eq;
    logic block_eq;
    logic acc_hit;
    logic rm_hit;
    logic evict;
    logic [SLOT_W-1:0] place_slot;

    lbp_ram #(
        .WIDTH (TAG_W),
        .DEPTH (SLOTS)
    ) u_tag_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata ({key_file_reg, key_block_reg}),
        .raddr (scan_idx_reg),
        .rdata (rd_tag)
    );

    lbp_rank_table #(
        .SLOTS (SLOTS)
    ) u_rank_table (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .valid_vec (valid_vec),
        .dirty_vec (dirty_vec),
        .rank_vec  (rank_vec),
        .count     (valid_count)
    );

    assign in_stall  = (state_reg != ST_IDLE);
    assign in_fire   = in_valid && !in_stall;
    assign finish_go = (state_reg == ST_FINISH) && (!out_valid_reg || !out_stall);

    assign is_access = (op_reg == OP_READ) || (op_reg == OP_WRITE);
    assign is_remove = (op_reg == OP_REMOVE);

    // shared tag compare
    assign rd_file       = rd_tag[TAG_W-1:BLOCK_NUM_BITS];
    assign rd_block      = rd_tag[BLOCK_NUM_BITS-1:0];
    assign cur_valid     = valid_vec[cmp_idx_reg];
    assign cur_rank_zero = (rank_vec[cmp_idx_reg] == '0);
    assign file_eq       = (rd_file == key_file_reg);
    assign block_eq      = (rd_block == key_block_reg);
    assign acc_hit       = cmp_en_reg && is_access && cur_valid && file_eq && block_eq;
    assign rm_hit        = cmp_en_reg && is_remove && cur_valid && file_eq;

    assign evict      = !hit_found_reg && !free_found_reg;
    assign place_slot = free_found_reg ? free_slot_reg : lru_slot_reg;
    assign ram_we     = finish_go && is_access && !hit_found_reg;
    assign ram_waddr  = place_slot;

    always_comb
    begin
        cmd = '{kind: CMD_NONE, slot: '0, dirty_wr: 1'b0, dirty_val: 1'b0};
        if (rm_hit)
        begin
            cmd.kind = CMD_REMOVE;
            cmd.slot = MAX_SLOT_W'(cmp_idx_reg);
        end
        else if (finish_go && is_access)
        begin
            priority if (hit_found_reg)
            begin
                cmd.slot = MAX_SLOT_W'(hit_slot_reg);
                if (op_reg == OP_READ)
                begin
                    cmd.kind = CMD_TOUCH;
                end
                else if (differs_reg)
                begin
                    cmd.kind = CMD_MARK_DIRTY;
                end
            end
            else if (free_found_reg)
            begin
                cmd.kind      = CMD_FILL;
                cmd.slot      = MAX_SLOT_W'(free_slot_reg);
                cmd.dirty_val = (op_reg == OP_WRITE) && differs_reg;
            end
            else
            begin
                cmd.kind      = CMD_TOUCH;
                cmd.slot      = MAX_SLOT_W'(lru_slot_reg);
                cmd.dirty_wr  = 1'b1;
                cmd.dirty_val = (op_reg == OP_WRITE) && differs_reg;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            scan_idx_reg   <= '0;
            cmp_en_reg     <= 1'b0;
            hit_found_reg  <= 1'b0;
            free_found_reg <= 1'b0;
            removed_reg    <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            cmp_en_reg <= (state_reg == ST_SCAN);
            if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (in_fire)
                    begin
                        state_reg      <= ST_SCAN;
                        scan_idx_reg   <= '0;
                        hit_found_reg  <= 1'b0;
                        free_found_reg <= 1'b0;
                        removed_reg    <= '0;
                    end
                end
                ST_SCAN:
                begin
                    scan_idx_reg <= scan_idx_reg + SLOT_W'(1);
                    if (scan_idx_reg == SLOT_W'(SLOTS - 1))
                    begin
                        state_reg <= ST_DRAIN;
                    end
                end
                ST_DRAIN:
                begin
                    state_reg <= ST_FINISH;
                end
                ST_FINISH:
                begin
                    if (finish_go)
                    begin
                        state_reg     <= ST_IDLE;
                        out_valid_reg <= 1'b1;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
            if (acc_hit && !hit_found_reg)
            begin
                hit_found_reg <= 1'b1;
            end
            if (cmp_en_reg && is_access && !cur_valid && !free_found_reg)
            begin
                free_found_reg <= 1'b1;
            end
            if (rm_hit)
            begin
                removed_reg <= removed_reg + COUNT_W'(1);
            end
        end
    end

    // scan captures and result payload
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            op_reg        <= opcode;
            key_file_reg  <= file_id;
            key_block_reg <= block_num;
            differs_reg   <= content_differs;
        end
        if (acc_hit && !hit_found_reg)
        begin
            hit_slot_reg <= cmp_idx_reg;
        end
        if (cmp_en_reg && is_access && !cur_valid && !free_found_reg)
        begin
            free_slot_reg <= cmp_idx_reg;
        end
        if (cmp_en_reg && is_access && cur_valid && cur_rank_zero)
        begin
            lru_slot_reg  <= cmp_idx_reg;
            vic_file_reg  <= rd_file;
            vic_block_reg <= rd_block;
        end
        cmp_idx_reg <= scan_idx_reg;
        if (finish_go)
        begin
            hit_reg           <= is_access && hit_found_reg;
            slot_reg          <= !is_access ? '0 :
                                 (hit_found_reg ? hit_slot_reg : place_slot);
            victim_valid_reg  <= is_access && evict;
            victim_dirty_reg  <= is_access && evict && dirty_vec[lru_slot_reg];
            victim_file_reg   <= (is_access && evict) ? vic_file_reg : '0;
            victim_block_reg  <= (is_access && evict) ? vic_block_reg : '0;
            removed_count_reg <= is_remove ? removed_reg : '0;
        end
    end

    assign out_valid     = out_valid_reg;
    assign hit           = hit_reg;
    assign slot          = slot_reg;
    assign victim_valid  = victim_valid_reg;
    assign victim_dirty  = victim_dirty_reg;
    assign victim_file   = victim_file_reg;
    assign victim_block  = victim_block_reg;
    assign removed_count = removed_count_reg;

    a_hit_never_evicts: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> !(hit_reg && victim_valid_reg))
        else $error("hit transaction reports a victim");

    a_remove_result_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (removed_count_reg != '0)) |->
            (!hit_reg && (slot_reg == '0) && !victim_valid_reg))
        else $error("remove transaction reports a lookup result");

    a_eviction_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        (finish_go && is_access && evict) |-> (valid_count == COUNT_W'(SLOTS)))
        else $error("eviction while a free slot exists");

endmodule
